// File: src/iir3_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iir3_pkg
// Shared types and constants for the third-order direct-form-I IIR filter.
// ----------------------------------------------------------------------------
package iir3_pkg;

    localparam int SAMPLE_W  = 16;
    localparam int COEF_W    = 24;
    localparam int PROD_W    = SAMPLE_W + COEF_W;   // one coefficient times one sample
    localparam int TERM_W    = PROD_W + 1;          // b*x - a*y of one tap
    localparam int ACC_W     = PROD_W + 4;          // seven products plus rounding
    localparam int NUM_TAPS  = 3;
    localparam int CFG_IDX_W = 3;

    localparam int COEF_FRAC_BITS_DEF = 20;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_COEF_B0 = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_B1 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_B2 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_B3 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_A1 = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_A2 = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_A3 = 3'd6;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample_in;
        logic                       start_of_signal;
    } t_in_item;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample_out;
        logic                       clipped;
    } t_out_item;

endpackage

// File: src/iir_third_order_direct_form_one.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iir_third_order_direct_form_one
// Third-order direct-form-I IIR filter, 16-bit samples, 24-bit coefficients.
// Output: the result is registered into the output register on the input transfer.
// Throughput: one sample per cycle while the output is not stalled; the y1 feedback
// path into the first tap register is combinational through the seven multipliers, the adder tree and round/saturate.
// Reset: synchronous active low; clears coefficients, tap history and output valid.
// ----------------------------------------------------------------------------
module iir_third_order_direct_form_one #(
    parameter int COEF_FRAC_BITS = iir3_pkg::COEF_FRAC_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [iir3_pkg::CFG_IDX_W-1:0]      i_cfg_addr,
    input  logic [iir3_pkg::COEF_W-1:0]         i_cfg_data,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  iir3_pkg::t_in_item                  i_in_data,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output iir3_pkg::t_out_item                 o_out_data
);
    import iir3_pkg::*;

    logic signed [COEF_W-1:0]   r_coef_b [0:NUM_TAPS];
    logic signed [COEF_W-1:0]   r_coef_a [1:NUM_TAPS];

    logic                       r_out_valid;
    t_out_item                  r_out_data;

    logic                       w_xfer_in;
    logic signed [SAMPLE_W-1:0] w_x_chain [0:NUM_TAPS];
    logic signed [SAMPLE_W-1:0] w_y_chain [0:NUM_TAPS];
    logic signed [TERM_W-1:0]   w_term    [1:NUM_TAPS];
    logic signed [PROD_W-1:0]   w_prod0;
    logic signed [ACC_W-1:0]    w_acc;
    logic signed [SAMPLE_W-1:0] w_y;
    logic                       w_clipped;

    // output register frees up in the same cycle it is drained
    assign o_in_ready = !r_out_valid || i_out_ready;
    assign w_xfer_in  = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= NUM_TAPS; k++) begin
                r_coef_b[k] <= '0;
            end
            for (int k = 1; k <= NUM_TAPS; k++) begin
                r_coef_a[k] <= '0;
            end
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                REG_COEF_B0: r_coef_b[0] <= i_cfg_data;
                REG_COEF_B1: r_coef_b[1] <= i_cfg_data;
                REG_COEF_B2: r_coef_b[2] <= i_cfg_data;
                REG_COEF_B3: r_coef_b[3] <= i_cfg_data;
                REG_COEF_A1: r_coef_a[1] <= i_cfg_data;
                REG_COEF_A2: r_coef_a[2] <= i_cfg_data;
                REG_COEF_A3: r_coef_a[3] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // head of the chain: new sample in, new output fed back
    assign w_x_chain[0] = i_in_data.sample_in;
    assign w_y_chain[0] = w_y;

    genvar g;
    generate
        for (g = 1; g <= NUM_TAPS; g++) begin : g_tap
            iir3_tap_cell u_cell (
                .i_clk    (i_clk),
                .i_rst_n  (i_rst_n),
                .i_shift  (w_xfer_in),
                .i_clear  (i_in_data.start_of_signal),
                .i_x      (w_x_chain[g-1]),
                .i_y      (w_y_chain[g-1]),
                .i_coef_b (r_coef_b[g]),
                .i_coef_a (r_coef_a[g]),
                .o_x      (w_x_chain[g]),
                .o_y      (w_y_chain[g]),
                .o_term   (w_term[g])
            );
        end
    endgenerate

    assign w_prod0 = r_coef_b[0] * i_in_data.sample_in;

    always_comb begin
        w_acc = ACC_W'(w_prod0);
        for (int k = 1; k <= NUM_TAPS; k++) begin
            w_acc = w_acc + ACC_W'(w_term[k]);
        end
    end

    iir3_round_sat #(
        .COEF_FRAC_BITS (COEF_FRAC_BITS)
    ) u_round_sat (
        .i_acc     (w_acc),
        .o_sample  (w_y),
        .o_clipped (w_clipped)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_xfer_in) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_xfer_in) begin
            r_out_data.sample_out <= w_y;
            r_out_data.clipped    <= w_clipped;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

// File: src/iir3_tap_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iir3_tap_cell
// One delay tap: holds one past input and one past output, hands them to the
// next cell on every transfer and forms b*x - a*y for its delay.
// ----------------------------------------------------------------------------
module iir3_tap_cell (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_shift,
    input  logic                                   i_clear,
    input  logic signed [iir3_pkg::SAMPLE_W-1:0]   i_x,
    input  logic signed [iir3_pkg::SAMPLE_W-1:0]   i_y,
    input  logic signed [iir3_pkg::COEF_W-1:0]     i_coef_b,
    input  logic signed [iir3_pkg::COEF_W-1:0]     i_coef_a,
    output logic signed [iir3_pkg::SAMPLE_W-1:0]   o_x,
    output logic signed [iir3_pkg::SAMPLE_W-1:0]   o_y,
    output logic signed [iir3_pkg::TERM_W-1:0]     o_term
);
    import iir3_pkg::*;

    logic signed [SAMPLE_W-1:0] r_x;
    logic signed [SAMPLE_W-1:0] r_y;
    logic signed [SAMPLE_W-1:0] w_x_eff;
    logic signed [SAMPLE_W-1:0] w_y_eff;
    logic signed [PROD_W-1:0]   w_bx;
    logic signed [PROD_W-1:0]   w_ay;

    // start of signal zeroes the history before this sample uses it
    assign w_x_eff = i_clear ? '0 : r_x;
    assign w_y_eff = i_clear ? '0 : r_y;

    assign w_bx   = i_coef_b * w_x_eff;
    assign w_ay   = i_coef_a * w_y_eff;
    assign o_term = $signed({w_bx[PROD_W-1], w_bx}) - $signed({w_ay[PROD_W-1], w_ay});

    assign o_x = w_x_eff;
    assign o_y = w_y_eff;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x <= '0;
            r_y <= '0;
        end else if (i_shift) begin
            r_x <= i_x;
            r_y <= i_y;
        end
    end

endmodule

// File: src/iir3_round_sat.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iir3_round_sat
// Rounds the accumulator half up to an integer and saturates it to 16 bits.
// ----------------------------------------------------------------------------
module iir3_round_sat #(
    parameter int COEF_FRAC_BITS = iir3_pkg::COEF_FRAC_BITS_DEF
) (
    input  logic signed [iir3_pkg::ACC_W-1:0]     i_acc,
    output logic signed [iir3_pkg::SAMPLE_W-1:0]  o_sample,
    output logic                                  o_clipped
);
    import iir3_pkg::*;

    localparam logic signed [ACC_W-1:0] HALF = ACC_W'(1) <<< (COEF_FRAC_BITS - 1);

    logic signed [ACC_W-1:0]      w_rnd;
    logic signed [ACC_W-1:0]      w_q;
    logic [ACC_W-SAMPLE_W:0]      w_top;

    assign w_rnd = i_acc + HALF;
    assign w_q   = w_rnd >>> COEF_FRAC_BITS;   // arithmetic shift is a floor
    assign w_top = w_q[ACC_W-1:SAMPLE_W-1];

    // in range only when every bit above the result matches its sign
    assign o_clipped = !((&w_top) || !(|w_top));

    always_comb begin
        if (!o_clipped) begin
            o_sample = w_q[SAMPLE_W-1:0];
        end else if (w_q[ACC_W-1]) begin
            o_sample = {1'b1, {(SAMPLE_W-1){1'b0}}};
        end else begin
            o_sample = {1'b0, {(SAMPLE_W-1){1'b1}}};
        end
    end

endmodule
